// ===== src/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } req_op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } rsp_status_type;

   localparam int unsigned EntriesWidth = 5;

   // request transaction payload
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] push_value;
   } req_payload_type;

   // result transaction payload
   typedef struct packed {
      logic signed [31:0]      pop_value;
      logic [1:0]              status;
      logic [EntriesWidth-1:0] entries;
   } rsp_payload_type;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic load_pop;
   } deq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pop_ok;
   } deq_stat_type;

endpackage

`default_nettype wire

// ===== src/deq_datapath.sv =====
// ---------------------------------------------------------------------------
// deq_datapath
// Ring buffer storage, head/tail pointers, fill count and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  deq_pkg::req_payload_type  req_payload,
   input  deq_pkg::deq_cmd_type      cmd,
   output deq_pkg::deq_stat_type     stat,
   output deq_pkg::rsp_payload_type  rsp_payload
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastIndex = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   mem [DEPTH];
   logic [31:0]   rd_data_ff;
   deq_pkg::rsp_payload_type out_ff;

   deq_pkg::req_op_type op;
   logic          is_push, full, empty, push_ok, pop_ok;
   logic [AW-1:0] head_up, head_dn, tail_up, tail_dn;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    status_code;

   // wrapping pointer neighbors
   assign head_up = (head_ff == LastIndex) ? '0 : head_ff + AW'(1);
   assign head_dn = (head_ff == '0) ? LastIndex : head_ff - AW'(1);
   assign tail_up = (tail_ff == LastIndex) ? '0 : tail_ff + AW'(1);
   assign tail_dn = (tail_ff == '0) ? LastIndex : tail_ff - AW'(1);

   // request decode
   always_comb begin
      op      = deq_pkg::req_op_type'(req_payload.req_type);
      is_push = (op == deq_pkg::OP_PUSH_BACK) || (op == deq_pkg::OP_PUSH_FRONT);
      full    = (count_ff == FullCount);
      empty   = (count_ff == '0);
      push_ok = is_push && !full;
      pop_ok  = !is_push && !empty;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_addr  = tail_ff;
      rd_addr  = head_ff;
      status_code = deq_pkg::ST_OK;
      case (op)
         deq_pkg::OP_PUSH_BACK: begin
            wr_addr = tail_ff;
            if (push_ok) begin
               tail_in  = tail_up;
               count_in = count_ff + CW'(1);
            end else begin
               status_code = deq_pkg::ST_FULL;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            wr_addr = head_dn;
            if (push_ok) begin
               head_in  = head_dn;
               count_in = count_ff + CW'(1);
            end else begin
               status_code = deq_pkg::ST_FULL;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            rd_addr = head_ff;
            if (pop_ok) begin
               head_in  = head_up;
               count_in = count_ff - CW'(1);
            end else begin
               status_code = deq_pkg::ST_EMPTY;
            end
         end
         default: begin
            rd_addr = tail_dn;
            if (pop_ok) begin
               tail_in  = tail_dn;
               count_in = count_ff - CW'(1);
            end else begin
               status_code = deq_pkg::ST_EMPTY;
            end
         end
      endcase
   end

   assign stat.pop_ok = pop_ok;

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage with registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && push_ok) begin
         mem[wr_addr] <= req_payload.push_value;
      end
      if (cmd.accept && pop_ok) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         out_ff.pop_value <= '0;
         out_ff.status    <= status_code;
         out_ff.entries   <= deq_pkg::EntriesWidth'(count_in);
      end else if (cmd.load_pop) begin
         out_ff.pop_value <= rd_data_ff;
      end
   end

   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// ===== src/deq_ctrl.sv =====
// ---------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: accepts requests and sequences the pop read cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  deq_pkg::deq_stat_type  stat,
   output deq_pkg::deq_cmd_type   cmd
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.load_pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = !rsp_valid_ff || rsp_ready;
            cmd.accept = req_valid && req_ready;
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
            if (cmd.accept) begin
               if (stat.pop_ok) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.load_pop = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/double_ended_queue_unit.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit words held in a ring buffer of DEPTH slots.
// ---------------------------------------------------------------------------
// channel   ports                               direction  carries
// request   req_valid / req_ready / req_payload  in         op and push word
// result    rsp_valid / rsp_ready / rsp_payload  out        pop word, status,
//                                                           entry count
//
// a push or a failed pop gives its result in the cycle after acceptance; a
// successful pop first passes through S_READ, as the storage array read is registered.
// a new request is taken in the cycle its predecessor's result is taken.
// synchronous reset clears pointers, count and handshake state; storage is
// not cleared, since no slot is read before it is written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  deq_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output deq_pkg::rsp_payload_type  rsp_payload
);

   deq_pkg::deq_cmd_type  cmd;
   deq_pkg::deq_stat_type stat;

   // controller
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
